[rtl/md5_pkg.sv]
// ============================================================================
// md5_pkg
// Shared types, constants and round tables for the MD5 engine.
// ============================================================================
`default_nettype none

package md5_pkg;

    // Working / chaining words a, b, c, d
    typedef struct packed {
        logic [31:0] d;
        logic [31:0] c;
        logic [31:0] b;
        logic [31:0] a;
    } md5_words_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD2,
        ST_DONE
    } md5_state_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int unsigned ROUNDS = 64;

    // Message word index used in round i
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [7:0] prod;
        prod = 8'd0;
        case (i[5:4])
            2'd0: prod = {2'b00, i};
            2'd1: prod = 8'(5 * {2'b00, i} + 8'd1);
            2'd2: prod = 8'(3 * {2'b00, i} + 8'd5);
            2'd3: prod = 8'(7 * {2'b00, i});
            default: prod = 8'd0;
        endcase
        return prod[3:0];
    endfunction

    // Left-rotate amount of round i
    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] r;
        r = 5'd0;
        case ({i[5:4], i[1:0]})
            4'h0: r = 5'd7;
            4'h1: r = 5'd12;
            4'h2: r = 5'd17;
            4'h3: r = 5'd22;
            4'h4: r = 5'd5;
            4'h5: r = 5'd9;
            4'h6: r = 5'd14;
            4'h7: r = 5'd20;
            4'h8: r = 5'd4;
            4'h9: r = 5'd11;
            4'hA: r = 5'd16;
            4'hB: r = 5'd23;
            4'hC: r = 5'd6;
            4'hD: r = 5'd10;
            4'hE: r = 5'd15;
            4'hF: r = 5'd21;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Additive round constant of round i
    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        k = 32'd0;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'd0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[rtl/md5_in_if.sv]
// ============================================================================
// md5_in_if
// Input channel: one message byte or an end-of-message marker per beat.
// ============================================================================
`default_nettype none

interface md5_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

[rtl/md5_out_if.sv]
// ============================================================================
// md5_out_if
// Output channel: one 128-bit digest per beat, split in two 64-bit halves.
// ============================================================================
`default_nettype none

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    modport source (output valid, output digest_low, output digest_high, input ready);
    modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

`default_nettype wire

[rtl/md5_round.sv]
// ============================================================================
// md5_round
// One MD5 step: round function, constant and message add, rotate, add b.
// ============================================================================
`default_nettype none

module md5_round (
    input  md5_pkg::md5_words_t state_in,
    input  logic [5:0]          round_idx,
    input  logic [31:0]         msg_word,
    output md5_pkg::md5_words_t state_out
);

    logic [31:0] f;
    logic [31:0] t;
    logic [63:0] rot_wide;
    logic [4:0]  r;

    always_comb
    begin
        f = 32'd0;
        case (round_idx[5:4])
            2'd0: f = (state_in.b & state_in.c) | (~state_in.b & state_in.d);
            2'd1: f = (state_in.d & state_in.b) | (~state_in.d & state_in.c);
            2'd2: f = state_in.b ^ state_in.c ^ state_in.d;
            2'd3: f = state_in.c ^ (state_in.b | ~state_in.d);
            default: f = 32'd0;
        endcase
    end

    assign t        = f + state_in.a + md5_pkg::round_const(round_idx) + msg_word;
    assign r        = md5_pkg::rot_amount(round_idx);
    // upper half of {t,t} << r is t rotated left by r
    assign rot_wide = {t, t} << r;

    always_comb
    begin
        state_out.a = state_in.d;
        state_out.d = state_in.c;
        state_out.c = state_in.b;
        state_out.b = state_in.b + rot_wide[63:32];
    end

endmodule

`default_nettype wire

[rtl/md5_hash_engine.sv]
// ============================================================================
// md5_hash_engine
// Streaming MD5 digest: bytes in, one 128-bit digest out per message.
// ============================================================================
// Usage: send message bytes as beats with kind = 0, then one beat with
// kind = 1 to close the message. Ready stays high for byte beats, except
// after the 64th byte of each block, after which the engine runs the 64
// rounds of MD5 one per cycle through a single shared round unit and then
// folds the result into the chaining words; ready is low meanwhile. The end
// beat pads the open block and compresses it, and when fewer than 8 bytes
// were free after the 0x80 pad byte a second block follows; finally the
// digest moves into the output register once that register has drained.
// The digest beat holds word A in digest_low[31:0], B in [63:32], C in
// digest_high[31:0], D in [63:32]. Bytes of the next message are accepted
// while a digest beat is waiting. The message length is counted in a
// 64-bit byte counter and the bit length is taken modulo 2^64.
// ============================================================================
`default_nettype none

module md5_hash_engine (
    input  wire logic   clk,
    input  wire logic   rst_n,
    md5_in_if.sink      in_ch,
    md5_out_if.source   out_ch
);

    md5_pkg::md5_state_t state_reg, state_next;
    md5_pkg::md5_words_t chain_reg, chain_next;
    md5_pkg::md5_words_t work_reg, work_next;
    md5_pkg::md5_words_t round_out;
    md5_pkg::md5_words_t init_words;

    logic [31:0] block_reg [16];
    logic [31:0] block_next [16];

    logic [63:0] count_reg, count_next;
    logic [5:0]  round_reg, round_next;
    logic        final_reg, final_next;   // closing blocks of a message
    logic        extra_reg, extra_next;   // length goes in a second block

    logic        out_valid_reg, out_valid_next;
    logic [63:0] dig_low_reg, dig_low_next;
    logic [63:0] dig_high_reg, dig_high_next;

    logic        in_fire;
    logic        out_free;
    logic [5:0]  pos;
    logic [3:0]  wsel;
    logic [1:0]  lane;
    logic [63:0] bit_len;
    logic [31:0] msg_word;

    assign init_words = '{d: md5_pkg::INIT_D, c: md5_pkg::INIT_C,
                          b: md5_pkg::INIT_B, a: md5_pkg::INIT_A};

    assign in_ch.ready = (state_reg == md5_pkg::ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign pos     = count_reg[5:0];
    assign wsel    = pos[5:2];
    assign lane    = pos[1:0];
    assign bit_len = {count_reg[60:0], 3'b000};

    assign msg_word = block_reg[md5_pkg::msg_index(round_reg)];

    md5_round u_round (
        .state_in  (work_reg),
        .round_idx (round_reg),
        .msg_word  (msg_word),
        .state_out (round_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        block_next     = block_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        final_next     = final_reg;
        extra_next     = extra_reg;
        out_valid_next = out_valid_reg;
        dig_low_next   = dig_low_reg;
        dig_high_next  = dig_high_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    work_next  = chain_reg;
                    round_next = 6'd0;
                    if (!in_ch.kind)
                    begin
                        block_next[wsel][{lane, 3'b000} +: 8] = in_ch.data_byte;
                        count_next = count_reg + 64'd1;
                        final_next = 1'b0;
                        extra_next = 1'b0;
                        if (pos == 6'd63)
                        begin
                            state_next = md5_pkg::ST_ROUND;
                        end
                    end
                    else
                    begin
                        // pad byte at pos, zeros after it
                        for (int k = 0; k < 16; k++)
                        begin
                            if (4'(k) > wsel)
                            begin
                                block_next[k] = 32'd0;
                            end
                        end
                        for (int j = 0; j < 4; j++)
                        begin
                            if (2'(j) == lane)
                            begin
                                block_next[wsel][j*8 +: 8] = md5_pkg::PAD_BYTE;
                            end
                            else if (2'(j) > lane)
                            begin
                                block_next[wsel][j*8 +: 8] = 8'd0;
                            end
                        end
                        final_next = 1'b1;
                        if (pos[5:3] == 3'd7)
                        begin
                            extra_next = 1'b1;
                        end
                        else
                        begin
                            extra_next    = 1'b0;
                            block_next[14] = bit_len[31:0];
                            block_next[15] = bit_len[63:32];
                        end
                        state_next = md5_pkg::ST_ROUND;
                    end
                end
            end

            md5_pkg::ST_ROUND:
            begin
                work_next  = round_out;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(md5_pkg::ROUNDS - 1))
                begin
                    state_next = md5_pkg::ST_ADD;
                end
            end

            md5_pkg::ST_ADD:
            begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                if (!final_reg)
                begin
                    state_next = md5_pkg::ST_IDLE;
                end
                else if (extra_reg)
                begin
                    state_next = md5_pkg::ST_PAD2;
                end
                else
                begin
                    state_next = md5_pkg::ST_DONE;
                end
            end

            md5_pkg::ST_PAD2:
            begin
                // second closing block: zeros and the bit length
                for (int k = 0; k < 14; k++)
                begin
                    block_next[k] = 32'd0;
                end
                block_next[14] = bit_len[31:0];
                block_next[15] = bit_len[63:32];
                extra_next     = 1'b0;
                work_next      = chain_reg;
                round_next     = 6'd0;
                state_next     = md5_pkg::ST_ROUND;
            end

            md5_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dig_low_next   = {chain_reg.b, chain_reg.a};
                    dig_high_next  = {chain_reg.d, chain_reg.c};
                    chain_next     = init_words;
                    count_next     = 64'd0;
                    final_next     = 1'b0;
                    state_next     = md5_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::ST_IDLE;
            chain_reg     <= init_words;
            count_reg     <= 64'd0;
            round_reg     <= 6'd0;
            final_reg     <= 1'b0;
            extra_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            final_reg     <= final_next;
            extra_reg     <= extra_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: block store, working words, digest register
    always_ff @(posedge clk)
    begin
        block_reg    <= block_next;
        work_reg     <= work_next;
        dig_low_reg  <= dig_low_next;
        dig_high_reg <= dig_high_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.digest_low  = dig_low_reg;
    assign out_ch.digest_high = dig_high_reg;

endmodule

`default_nettype wire

[tb/md5_digest_checker.sv]
// ============================================================================
// md5_digest_checker
// Watches both channels of the MD5 engine. Every byte and end beat taken on
// the input feeds a local MD5 model, each end beat queues the digest it must
// produce, and each digest beat on the output is checked against the oldest
// one waiting. Failures and the count of digests still due go to the top.
// ============================================================================
`timescale 1ns / 1ps

module md5_digest_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    md5_in_if         in_mon,
    md5_out_if        out_mon,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } digest_t;

    localparam logic [31:0] IV [4] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476};
    localparam logic [7:0]  PAD_MARK = 8'h80;

    // left-rotate per round, indexed by {round / 16, round % 4}
    localparam int unsigned SHIFT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                           4, 11, 16, 23, 6, 10, 15, 21};

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    logic [31:0] chain_w [4];
    logic [31:0] block_w [16];
    logic [63:0] msg_bytes;
    digest_t     digest_q [$];
    digest_t     seen;

    // little-endian byte lane write; lane 0 clears the upper lanes
    function automatic void load_byte(input logic [5:0] pos, input logic [7:0] val);
        if (pos[1:0] == 2'd0)
        begin
            block_w[pos[5:2]] = {24'd0, val};
        end
        else
        begin
            block_w[pos[5:2]] = block_w[pos[5:2]] | ({24'd0, val} << (8 * pos[1:0]));
        end
    endfunction

    function automatic void fold_block();
        logic [31:0] a, b, c, d, f, t;
        int          g;
        int unsigned r;
        a = chain_w[0];
        b = chain_w[1];
        c = chain_w[2];
        d = chain_w[3];
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
            begin
                f = (b & c) | (~b & d);
                g = i;
            end
            else if (i < 32)
            begin
                f = (d & b) | (~d & c);
                g = (5 * i + 1) % 16;
            end
            else if (i < 48)
            begin
                f = b ^ c ^ d;
                g = (3 * i + 5) % 16;
            end
            else
            begin
                f = c ^ (b | ~d);
                g = (7 * i) % 16;
            end
            t = f + a + SINE_K[i] + block_w[g];
            r = SHIFT[(i / 16) * 4 + (i % 4)];
            a = d;
            d = c;
            c = b;
            b = b + ((t << r) | (t >> (32 - r)));
        end
        chain_w[0] = chain_w[0] + a;
        chain_w[1] = chain_w[1] + b;
        chain_w[2] = chain_w[2] + c;
        chain_w[3] = chain_w[3] + d;
    endfunction

    // pad, append the bit length, queue the digest, start a fresh message
    function automatic void close_message();
        logic [63:0] bit_len;
        logic [5:0]  pos;
        digest_t     dg;
        bit_len = msg_bytes << 3;
        pos     = msg_bytes[5:0];
        load_byte(pos, PAD_MARK);
        for (int p = pos + 1; p < 64; p++)
        begin
            load_byte(6'(p), 8'h00);
        end
        // no room for the length: spill into a block of its own
        if (pos >= 6'd56)
        begin
            fold_block();
            for (int w = 0; w < 16; w++)
            begin
                block_w[w] = 32'd0;
            end
        end
        block_w[14] = bit_len[31:0];
        block_w[15] = bit_len[63:32];
        fold_block();
        dg.lo = {chain_w[1], chain_w[0]};
        dg.hi = {chain_w[3], chain_w[2]};
        digest_q.push_back(dg);
        chain_w   = IV;
        msg_bytes = 64'd0;
    endfunction

    function automatic void flag(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s expected %h got %h", $realtime, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_w    = IV;
            msg_bytes  = 64'd0;
            digest_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (digest_q.size() == 0)
                begin
                    flag("unexpected digest, low half", 64'd0, out_mon.digest_low);
                end
                else
                begin
                    seen = digest_q.pop_front();
                    if (out_mon.digest_low !== seen.lo)
                    begin
                        flag("digest_low", seen.lo, out_mon.digest_low);
                    end
                    if (out_mon.digest_high !== seen.hi)
                    begin
                        flag("digest_high", seen.hi, out_mon.digest_high);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                // kind high closes the message; data_byte is don't-care then
                if (in_mon.kind)
                begin
                    close_message();
                end
                else
                begin
                    load_byte(msg_bytes[5:0], in_mon.data_byte);
                    msg_bytes = msg_bytes + 64'd1;
                    if (msg_bytes[5:0] == 6'd0)
                    begin
                        fold_block();
                    end
                end
            end
            pending = digest_q.size();
        end
    end

endmodule

[tb/tb.sv]
// ============================================================================
// tb
// Top of the MD5 engine bench. Drives byte and end beats into the engine,
// stalls the digest side at random, and gives the verdict from the checker.
// A few hand-picked messages run first, then random messages whose lengths
// lean toward the padding boundaries of a 64-byte block.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    // input beat kinds
    localparam logic MSG_BYTE = 1'b0;
    localparam logic MSG_END  = 1'b1;

    localparam int ITEM_BUDGET = 1600;
    localparam int IDLE_PCT    = 23;

    // message lengths around the pad/length boundaries: last fit, first
    // spill, full block, and the same one block later
    localparam int PAD_EDGE_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    logic clk = 1'b0;
    logic rst_n;
    logic no_idle;
    int   beats_sent;
    int   fail_count;
    int   pending;
    int   msg_len;
    int   roll;
    bit   drained_once;

    md5_in_if  in_ch ();
    md5_out_if out_ch ();

    md5_hash_engine i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    md5_digest_checker i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // digest side back-pressure; no_idle holds it open during the quiet stretch
    always @(negedge clk)
    begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Called at a falling edge, returns at a falling edge. Within this task valid
    // is only lowered inside the gap loop, so it never drops and rises in one step.
    task automatic send_beat(input logic k, input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= k;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
        @(negedge clk);
    endtask

    // random bytes, then the end beat with a random (ignored) data byte
    task automatic send_message(input int len);
        for (int n = 0; n < len; n++)
        begin
            send_beat(MSG_BYTE, 8'($urandom_range(255)));
        end
        send_beat(MSG_END, 8'($urandom_range(255)));
    endtask

    // hold the input off until every queued digest has come out
    task automatic drain_digests();
        while (pending != 0)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        no_idle         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = MSG_BYTE;
        in_ch.data_byte = 8'h00;
        beats_sent      = 0;
        drained_once    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed ---
        // empty message, data byte all ones on the end beat (must be ignored)
        send_beat(MSG_END, 8'hFF);
        // back-to-back end beats: a second empty message
        send_beat(MSG_END, 8'h00);
        // single byte extremes
        send_beat(MSG_BYTE, 8'h00);
        send_beat(MSG_END, 8'h5A);
        send_beat(MSG_BYTE, 8'hFF);
        send_beat(MSG_END, 8'hA5);
        // "abc"
        send_beat(MSG_BYTE, 8'h61);
        send_beat(MSG_BYTE, 8'h62);
        send_beat(MSG_BYTE, 8'h63);
        send_beat(MSG_END, 8'h00);
        // alternating bit patterns
        send_beat(MSG_BYTE, 8'h55);
        send_beat(MSG_BYTE, 8'hAA);
        send_beat(MSG_END, 8'hFF);
        drain_digests();

        // --- random messages ---
        // the boundary lengths go out once each before the weighted mix
        for (int e = 0; e < 10; e++)
        begin
            send_message(PAD_EDGE_LEN[e]);
        end
        while (beats_sent < ITEM_BUDGET)
        begin
            no_idle <= (beats_sent >= 500 && beats_sent < 800);
            if (!drained_once && beats_sent >= 1100)
            begin
                drained_once = 1'b1;
                drain_digests();
            end
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                msg_len = 0;
            end
            else if (roll < 33)
            begin
                msg_len = PAD_EDGE_LEN[$urandom_range(9)];
            end
            else if (roll < 36)
            begin
                msg_len = $urandom_range(300, 130);
            end
            else
            begin
                msg_len = $urandom_range(40, 1);
            end
            send_message(msg_len);
        end
        in_ch.valid <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        // then keep watching for stray digests
        repeat (150) @(negedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

    // watchdog: far beyond the length of a correct run
    initial
    begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
